// ===== design/tdpt_pkg.sv =====
// Package for the trial-division prime test core.
// Holds widths, sequencer state codes and the remainder unit handshake types.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package tdpt_pkg;

    localparam int VALUE_BITS = 31;
    // Odd divisors never climb beyond just above sqrt(2^VALUE_BITS).
    localparam int DIV_BITS   = (VALUE_BITS + 1) / 2 + 2;
    localparam int SQ_BITS    = VALUE_BITS + 2;
    localparam int CNT_BITS   = $clog2(VALUE_BITS);

    typedef logic [VALUE_BITS-1:0] t_value;
    typedef logic [DIV_BITS-1:0]   t_div;
    typedef logic [SQ_BITS-1:0]    t_sq;
    typedef logic [CNT_BITS-1:0]   t_cnt;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_CHECK = 2'd1;
    localparam logic [1:0] ST_DIV   = 2'd2;
    localparam logic [1:0] ST_OUT   = 2'd3;

    typedef struct packed {
        logic   start;
        t_value dividend;
        t_div   divisor;
    } t_rem_req;

    typedef struct packed {
        logic done;
        logic zero;
    } t_rem_rsp;

endpackage

`default_nettype wire

// ===== design/tdpt_rem.sv =====
// Shared restoring remainder unit: one quotient bit per cycle.
// Depends on tdpt_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tdpt_rem (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  tdpt_pkg::t_rem_req i_req,
    output tdpt_pkg::t_rem_rsp o_rsp
);
    import tdpt_pkg::*;

    logic              r_busy, n_busy;
    t_cnt              r_cnt,  n_cnt;
    t_value            r_dvd,  n_dvd;
    t_div              r_dvs,  n_dvs;
    t_div              r_rem,  n_rem;
    logic [DIV_BITS:0] w_trial;
    logic [DIV_BITS:0] w_diff;
    t_div              w_rem_next;

    always_comb begin
        w_trial    = {r_rem, r_dvd[VALUE_BITS-1]};
        w_diff     = w_trial - {1'b0, r_dvs};
        w_rem_next = w_diff[DIV_BITS] ? w_trial[DIV_BITS-1:0] : w_diff[DIV_BITS-1:0];
    end

    always_comb begin
        n_busy = r_busy;
        n_cnt  = r_cnt;
        n_dvd  = r_dvd;
        n_dvs  = r_dvs;
        n_rem  = r_rem;
        if (i_req.start) begin
            n_busy = 1'b1;
            n_cnt  = CNT_BITS'(VALUE_BITS - 1);
            n_dvd  = i_req.dividend;
            n_dvs  = i_req.divisor;
            n_rem  = '0;
        end else if (r_busy) begin
            n_rem = w_rem_next;
            n_dvd = {r_dvd[VALUE_BITS-2:0], 1'b0};
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == '0) begin
                n_busy = 1'b0;
            end
        end
    end

    assign o_rsp.done = r_busy && (r_cnt == '0);
    assign o_rsp.zero = (w_rem_next == '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_cnt  <= n_cnt;
        end
        r_dvd <= n_dvd;
        r_dvs <= n_dvs;
        r_rem <= n_rem;
    end

endmodule

`default_nettype wire

// ===== design/trial_division_prime_test_core.sv =====
// Trial-division prime test: sequencer over odd divisors plus shared remainder unit.
// Depends on tdpt_pkg and tdpt_rem.
//
//   channel  | valid    | ready    | payload
//   ---------+----------+----------+----------------------------------
//   input    | i_valid  | o_ready  | i_candidate
//   output   | o_valid  | i_ready  | o_tested_value, o_is_prime
//
// Candidates below 4 or even present their result in the cycle after the input beat.
// Each odd divisor d with d*d <= n runs through the remainder unit in turn, from 3 up;
// a prime n tries every such divisor, a composite stops at its first odd factor.
// Reset is synchronous, active low; the core comes up idle and ready.
// One candidate at a time; o_ready is low until the result beat is taken.
`timescale 1ns / 1ps
`default_nettype none

module trial_division_prime_test_core (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  wire                     i_valid,
    output logic                    o_ready,
    input  wire  [tdpt_pkg::VALUE_BITS-1:0] i_candidate,
    output logic                    o_valid,
    input  wire                     i_ready,
    output logic [tdpt_pkg::VALUE_BITS-1:0] o_tested_value,
    output logic                    o_is_prime
);
    import tdpt_pkg::*;

    logic [1:0] r_state, n_state;
    t_value     r_n,     n_n;
    t_div       r_d,     n_d;
    t_sq        r_sq,    n_sq;
    logic       r_prime, n_prime;
    t_rem_req   w_req;
    t_rem_rsp   w_rsp;
    logic       w_in_beat;
    logic       w_sq_fits;

    assign w_in_beat = i_valid && (r_state == ST_IDLE);
    assign w_sq_fits = (r_sq <= {2'b00, r_n});

    always_comb begin
        n_state        = r_state;
        n_n            = r_n;
        n_d            = r_d;
        n_sq           = r_sq;
        n_prime        = r_prime;
        w_req.start    = 1'b0;
        w_req.dividend = r_n;
        w_req.divisor  = r_d;
        case (r_state)
            ST_IDLE: begin
                if (w_in_beat) begin
                    n_n  = i_candidate;
                    n_d  = DIV_BITS'(3);
                    n_sq = SQ_BITS'(9);
                    if (i_candidate < VALUE_BITS'(2)) begin
                        n_prime = 1'b0;
                        n_state = ST_OUT;
                    end else if (i_candidate < VALUE_BITS'(4)) begin
                        n_prime = 1'b1;
                        n_state = ST_OUT;
                    end else if (!i_candidate[0]) begin
                        n_prime = 1'b0;
                        n_state = ST_OUT;
                    end else begin
                        n_state = ST_CHECK;
                    end
                end
            end
            ST_CHECK: begin
                if (w_sq_fits) begin
                    w_req.start = 1'b1;
                    n_state     = ST_DIV;
                end else begin
                    n_prime = 1'b1;
                    n_state = ST_OUT;
                end
            end
            ST_DIV: begin
                if (w_rsp.done) begin
                    if (w_rsp.zero) begin
                        n_prime = 1'b0;
                        n_state = ST_OUT;
                    end else begin
                        // advance to the next odd divisor: (d+2)^2 = d^2 + 4d + 4
                        n_d     = r_d + DIV_BITS'(2);
                        n_sq    = r_sq + {{(SQ_BITS-DIV_BITS-2){1'b0}}, r_d, 2'b00}
                                  + SQ_BITS'(4);
                        n_state = ST_CHECK;
                    end
                end
            end
            ST_OUT: begin
                if (i_ready) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    tdpt_rem u_rem (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (w_req),
        .o_rsp  (w_rsp)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
        r_n     <= n_n;
        r_d     <= n_d;
        r_sq    <= n_sq;
        r_prime <= n_prime;
    end

    assign o_ready        = (r_state == ST_IDLE);
    assign o_valid        = (r_state == ST_OUT);
    assign o_tested_value = r_n;
    assign o_is_prime     = r_prime;

endmodule

`default_nettype wire

// ===== design/tdpt_checker.sv =====
// Port-level checks for trial_division_prime_test_core, attached by bind.
// Depends on tdpt_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tdpt_checker (
    input wire                             i_clk,
    input wire                             i_rst_n,
    input wire                             i_valid,
    input wire                             o_ready,
    input wire [tdpt_pkg::VALUE_BITS-1:0]  i_candidate,
    input wire                             o_valid,
    input wire                             i_ready,
    input wire [tdpt_pkg::VALUE_BITS-1:0]  o_tested_value,
    input wire                             o_is_prime
);
    import tdpt_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_tested_value) && $stable(o_is_prime))
        else $error("result beat changed while stalled");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_ready && o_valid))
        else $error("input ready while a result is pending");

    a_busy_after_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> !o_ready)
        else $error("ready stayed high after an input beat");

    a_echo: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready ##1 o_valid |-> o_tested_value == $past(i_candidate))
        else $error("echoed value does not match candidate");

    a_prime_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_is_prime |->
            (o_tested_value[0] && o_tested_value != VALUE_BITS'(1))
            || o_tested_value == VALUE_BITS'(2))
        else $error("prime flag on an even value, zero or one");

endmodule

bind trial_division_prime_test_core tdpt_checker u_tdpt_checker (.*);

`default_nettype wire

// ===== tb/prime_result_checker.sv =====
// Checker for the trial-division prime test core: watches both channels,
// predicts each verdict by its own trial division and compares field by field.
// Depends on tdpt_pkg.
`timescale 1ns / 1ps

module prime_result_checker (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic             i_in_ready,
    input  tdpt_pkg::t_value i_candidate,
    input  logic             i_out_valid,
    input  logic             i_out_ready,
    input  tdpt_pkg::t_value i_tested_value,
    input  logic             i_is_prime,
    output int               o_fail_count,
    output int               o_pending
);
    import tdpt_pkg::*;

    typedef struct {
        t_value value;
        bit     prime;
    } t_prime_verdict;

    t_prime_verdict predicted_verdicts[$];
    int             fail_total    = 0;
    int             pending_count = 0;

    assign o_fail_count = fail_total;
    assign o_pending    = pending_count;

    function automatic bit has_no_divisor(t_value n);
        longint unsigned m;
        longint unsigned d;
        m = n;
        if (m < 2)
            return 1'b0;
        if (m < 4)
            return 1'b1;
        if (m % 2 == 0)
            return 1'b0;
        for (d = 3; d <= m / d; d += 2) begin
            if (m % d == 0)
                return 1'b0;
        end
        return 1'b1;
    endfunction

    always @(posedge i_clk) begin
        t_prime_verdict verdict;
        t_prime_verdict oldest;
        if (i_rst_n) begin
            if (i_in_valid && i_in_ready) begin
                verdict.value = i_candidate;
                verdict.prime = has_no_divisor(i_candidate);
                predicted_verdicts.push_back(verdict);
            end
            if (i_out_valid && i_out_ready) begin
                if (predicted_verdicts.size() == 0) begin
                    $error("unexpected result beat: tested_value %0d, is_prime %0d",
                           i_tested_value, i_is_prime);
                    fail_total++;
                end else begin
                    oldest = predicted_verdicts.pop_front();
                    if (i_tested_value !== oldest.value) begin
                        $error("tested_value: expected %0d, got %0d",
                               oldest.value, i_tested_value);
                        fail_total++;
                    end
                    if (i_is_prime !== oldest.prime) begin
                        $error("is_prime: expected %0d, got %0d (candidate %0d)",
                               oldest.prime, i_is_prime, oldest.value);
                        fail_total++;
                    end
                end
            end
            pending_count = predicted_verdicts.size();
        end
    end

endmodule

// ===== tb/testbench.sv =====
// Top of the trial-division prime test bench: clock, reset, candidate stimulus
// with bursty sender and stalling receiver, verdict. Depends on tdpt_pkg,
// trial_division_prime_test_core and prime_result_checker.
`timescale 1ns / 1ps

module testbench;
    import tdpt_pkg::*;

    localparam int RANDOM_BEATS = 78;
    localparam int LONG_HOLD    = 300;
    localparam int DRAIN_CYCLES = 20;

    logic   i_clk = 1'b0;
    logic   i_rst_n;
    logic   i_valid;
    logic   o_ready;
    t_value i_candidate;
    logic   o_valid;
    logic   i_ready;
    t_value o_tested_value;
    logic   o_is_prime;

    int     fail_count;
    int     pending;
    int     sent_beats    = 0;
    bit     hold_request  = 1'b0;
    bit     hold_done     = 1'b0;

    t_value directed_candidates[] = '{
        31'd0, 31'd1, 31'd2, 31'd3, 31'd4, 31'd5, 31'd9, 31'd15, 31'd25, 31'd49,
        31'd97, 31'd121, 31'd2047, 31'd63001, 31'd65521, 31'd16752649,
        31'd1073741824, 31'd715827882, 31'd1431655765,
        31'd2147483645, 31'd2147483646, 31'd2147483647
    };

    trial_division_prime_test_core DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_candidate    (i_candidate),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_tested_value (o_tested_value),
        .o_is_prime     (o_is_prime)
    );

    prime_result_checker u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_valid),
        .i_in_ready     (o_ready),
        .i_candidate    (i_candidate),
        .i_out_valid    (o_valid),
        .i_out_ready    (i_ready),
        .i_tested_value (o_tested_value),
        .i_is_prime     (o_is_prime),
        .o_fail_count   (fail_count),
        .o_pending      (pending)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Mostly small candidates; large ones get a small factor to keep the run short.
    function automatic t_value random_candidate();
        t_value     v;
        int unsigned factor;
        int unsigned pick;
        pick = $urandom_range(0, 9);
        if (pick < 6) begin
            v = t_value'($urandom_range(0, 4095));
        end else if (pick < 8) begin
            v = t_value'($urandom_range(4096, 262143));
        end else begin
            v = t_value'($urandom);
            case ($urandom_range(0, 5))
                0:       factor = 2;
                1:       factor = 3;
                2:       factor = 5;
                3:       factor = 7;
                4:       factor = 11;
                default: factor = 13;
            endcase
            v = v - t_value'(v % factor);
        end
        return v;
    endfunction

    task automatic offer_candidate(input t_value value);
        @(negedge i_clk);
        i_valid     <= 1'b1;
        i_candidate <= value;
        @(posedge i_clk);
        while (!o_ready)
            @(posedge i_clk);
        sent_beats++;
    endtask

    task automatic idle_sender(input int cycles);
        repeat (cycles) begin
            @(negedge i_clk);
            i_valid <= 1'b0;
        end
    endtask

    task automatic drain_results();
        idle_sender(1);
        wait (pending == 0);
    endtask

    // Receiver: random stall pattern, plus one long hold-off on request.
    initial begin
        int run;
        int mode;
        i_ready = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            if (hold_request && !hold_done) begin
                hold_done = 1'b1;
                repeat (LONG_HOLD) begin
                    @(negedge i_clk);
                    i_ready <= 1'b0;
                end
            end else begin
                run  = $urandom_range(1, 16);
                mode = $urandom_range(0, 3);
                repeat (run) begin
                    @(negedge i_clk);
                    case (mode)
                        0:       i_ready <= 1'b0;
                        3:       i_ready <= 1'($urandom_range(0, 1));
                        default: i_ready <= 1'b1;
                    endcase
                end
            end
        end
    end

    initial begin
        int burst;
        int gap;
        i_rst_n     = 1'b0;
        i_valid     = 1'b0;
        i_candidate = '0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_candidates[k]) begin
            offer_candidate(directed_candidates[k]);
            if ($urandom_range(0, 2) == 0)
                idle_sender($urandom_range(1, 4));
        end
        drain_results();

        hold_request = 1'b1;
        while (sent_beats < directed_candidates.size() + RANDOM_BEATS) begin
            burst = $urandom_range(1, 12);
            repeat (burst)
                offer_candidate(random_candidate());
            gap = $urandom_range(0, 5);
            if (gap > 0)
                idle_sender(gap);
        end
        drain_results();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (fail_count == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end

    initial begin
        #12_000_000;
        $display("testbench: errors");
        $finish;
    end

endmodule
